@@ rtl/fpme_pkg.sv @@
// Shared types and constants for the frame period median estimator.
// No dependencies; imported by the interfaces and all modules.
package fpme_pkg;

	// Field widths
	localparam int TS_W = 63;
	localparam int IV_W = 31;

	// Largest interval that can be stored
	localparam logic [IV_W-1:0] IV_MAX = {IV_W{1'b1}};

	// Commands from controller to datapath
	typedef struct packed {
		logic load_ts;    // capture incoming timestamp
		logic diff;       // form saturated interval, roll last timestamp
		logic insert;     // insert interval into sorted batch
		logic smooth;     // fold batch median into estimate
		logic load_out;   // move result into output register
	} fpme_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic rec;        // this tick carries an interval
		logic batch_done; // the insert just closed a batch
	} fpme_stat_t;

endpackage

@@ rtl/fpme_in_if.sv @@
// Input channel carrying one frame tick timestamp per item.
// Depends on fpme_pkg for the field width.
interface fpme_in_if;
	logic                       valid;
	logic                       ready;
	logic [fpme_pkg::TS_W-1:0]  timestamp_us;

	modport source (output valid, output timestamp_us, input ready);
	modport sink   (input valid, input timestamp_us, output ready);
endinterface

@@ rtl/fpme_out_if.sv @@
// Output channel carrying the period estimate and update flag per item.
// Depends on fpme_pkg for the field width.
interface fpme_out_if;
	logic                       valid;
	logic                       ready;
	logic                       updated;
	logic [fpme_pkg::IV_W-1:0]  frame_period_us;

	modport source (output valid, output updated, output frame_period_us, input ready);
	modport sink   (input valid, input updated, input frame_period_us, output ready);
endinterface

@@ rtl/fpme_ctrl.sv @@
// Sequencing state machine for the frame period median estimator.
// Depends on fpme_pkg for the command and status structs.
module fpme_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  fpme_pkg::fpme_stat_t  stat,
	output fpme_pkg::fpme_cmd_t   cmd
);
	import fpme_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIFF   = 3'd1;
	localparam logic [2:0] ST_INSERT = 3'd2;
	localparam logic [2:0] ST_SMOOTH = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// Next state and command decode
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_ts = 1'b1;
					state_d     = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = stat.rec;
				state_d    = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				cmd.smooth = stat.batch_done;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Never overwrite a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while stalled");

	// An insert is only issued for a tick that carries an interval
	a_insert_rec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> stat.rec)
		else $error("insert without interval");

	// An accepted item starts the interval step on the next cycle
	a_accept_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.diff)
		else $error("accepted item not processed");

endmodule

@@ rtl/fpme_dp.sv @@
// Datapath: interval forming, sorted batch row, estimate and output payload.
// Depends on fpme_pkg for widths and the command and status structs.
module fpme_dp #(
	parameter int SAMPLES = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [fpme_pkg::TS_W-1:0] timestamp_us,
	input  fpme_pkg::fpme_cmd_t       cmd,
	output fpme_pkg::fpme_stat_t      stat,
	output logic                      updated,
	output logic [fpme_pkg::IV_W-1:0] frame_period_us
);
	import fpme_pkg::*;

	localparam int CW  = $clog2(SAMPLES + 1);
	localparam int MID = SAMPLES / 2;

	logic [TS_W-1:0] ts_q;
	logic [TS_W-1:0] last_q;
	logic            rec_q;
	logic [IV_W-1:0] iv_q;
	logic [CW-1:0]   fill_q;
	logic            done_q;
	logic [IV_W-1:0] sm_q;
	logic            upd_out_q;
	logic [IV_W-1:0] period_out_q;

	logic [IV_W-1:0] row_q [SAMPLES];
	logic [IV_W-1:0] row_d [SAMPLES];
	logic [SAMPLES-1:0] le;

	logic [TS_W-1:0] diff_w;
	logic [IV_W-1:0] iv_sat;
	logic [IV_W:0]   sum_w;
	logic [CW-1:0]   fill_inc;

	// Saturated interval since the previous tick
	assign diff_w = ts_q - last_q;
	always_comb begin
		if (ts_q < last_q) begin
			iv_sat = '0;
		end else if (diff_w[TS_W-1:IV_W] != '0) begin
			iv_sat = IV_MAX;
		end else begin
			iv_sat = diff_w[IV_W-1:0];
		end
	end

	// Sorted insert: each cell compares itself against the new interval
	for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
		assign le[i] = (CW'(i) < fill_q) && (row_q[i] <= iv_q);
		if (i == 0) begin : g_first
			assign row_d[i] = le[i] ? row_q[i] : iv_q;
		end else begin : g_rest
			assign row_d[i] = le[i] ? row_q[i] : (le[i-1] ? iv_q : row_q[i-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int k = 0; k < SAMPLES; k++) begin
				row_q[k] <= row_d[k];
			end
		end
	end

	// Running estimate: average of median and previous estimate
	assign sum_w    = {1'b0, row_q[MID]} + {1'b0, sm_q};
	assign fill_inc = fill_q + CW'(1);

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_ts) begin
			ts_q <= timestamp_us;
		end
		if (cmd.diff) begin
			iv_q <= iv_sat;
		end
		if (cmd.load_out) begin
			upd_out_q    <= done_q;
			period_out_q <= sm_q;
		end
	end

	// Control state held in the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			rec_q  <= 1'b0;
			fill_q <= '0;
			done_q <= 1'b0;
			sm_q   <= '0;
		end else begin
			if (cmd.diff) begin
				rec_q  <= (last_q != '0);
				last_q <= ts_q;
				done_q <= 1'b0;
			end
			if (cmd.insert) begin
				if (fill_inc == CW'(SAMPLES)) begin
					fill_q <= '0;
					done_q <= 1'b1;
				end else begin
					fill_q <= fill_inc;
				end
			end
			if (cmd.smooth) begin
				sm_q <= (sm_q == '0) ? row_q[MID] : sum_w[IV_W:1];
			end
		end
	end

	assign stat.rec        = rec_q;
	assign stat.batch_done = done_q;
	assign updated         = upd_out_q;
	assign frame_period_us = period_out_q;

	// Fill count never reaches the batch size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(SAMPLES))
		else $error("fill count out of range");

	// A closed batch leaves the fill count at zero
	a_done_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (fill_q == '0))
		else $error("batch closed but fill count not cleared");

	// The row stays sorted around the median cell
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q > CW'(MID)) |-> (row_q[MID-1] <= row_q[MID]))
		else $error("batch row not sorted");

endmodule

@@ rtl/frame_period_median_estimator.sv @@
// Top level of the frame period median estimator.
// Depends on fpme_pkg, fpme_in_if, fpme_out_if, fpme_ctrl and fpme_dp.
//
// Usage:
//   ts_in carries one item per frame tick: the tick's timestamp in us.
//   est_out returns exactly one item per input item: the current smoothed
//   median frame period and a flag set when that tick closed a batch.
//   The first tick (or any tick while the stored timestamp is zero) only
//   records its timestamp. Each later tick inserts its saturated interval
//   into a sorted row of SAMPLES cells; a full row yields its middle cell
//   as the median, which seeds or is averaged into the estimate.
// Sequence: the controller steps through capture, interval, sorted insert,
//   smoothing and output load, and accepts the next item only after the
//   result is loaded into the output register.
// Reset: estimate, fill count and stored timestamp clear; no clearing pass.
// Stall: the output register holds a finished result while the next item is
//   accepted and processed; that item then waits in the last step until the
//   receiver takes the pending result.
module frame_period_median_estimator #(
	parameter int SAMPLES = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	fpme_in_if.sink    ts_in,
	fpme_out_if.source est_out
);
	import fpme_pkg::*;

	fpme_cmd_t  cmd;
	fpme_stat_t stat;

	// Sequencing
	fpme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ts_in.valid),
		.in_ready  (ts_in.ready),
		.out_valid (est_out.valid),
		.out_ready (est_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic and storage
	fpme_dp #(
		.SAMPLES (SAMPLES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.timestamp_us    (ts_in.timestamp_us),
		.cmd             (cmd),
		.stat            (stat),
		.updated         (est_out.updated),
		.frame_period_us (est_out.frame_period_us)
	);

endmodule
